// ----- src/iee_pkg.sv -----
// Shared types, widths and character codes for the integer expression evaluator.
// Used by iee_muldiv and integer_expression_evaluator; depends on nothing.
package iee_pkg;

  // Arithmetic width; every operand and the running sum wrap at this size.
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  // Decimal base for the number accumulator
  localparam int RADIX = 10;

  // Operator that applies the number just read to the product term
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } mulop_t;

  // Operator character held while the current number is closed
  typedef enum logic [2:0] {
    K_MUL = 3'd0,
    K_DIV = 3'd1,
    K_ADD = 3'd2,
    K_SUB = 3'd3,
    K_EQ  = 3'd4
  } char_kind_t;

  // Request to the serial multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctl_t;

  // Magnitude of a two's complement value, as an unsigned number
  function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] m;
    m = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

endpackage

// ----- src/integer_expression_evaluator.sv -----
// Top level of the infix integer expression evaluator: parser control, sum and output beat.
// Depends on iee_pkg and instantiates iee_muldiv.
//
// Usage:
//   Input channel: one ASCII character per beat on char_code, in_valid / in_stall.
//   Digits build a decimal number, '*' and '/' bind tighter than '+' and '-', '='
//   ends the expression. All other characters are taken and ignored.
//   Output channel: one beat per '=' on value / div_zero, out_valid / out_stall.
//   value is the 32-bit wrapped result, or 0 with div_zero set after a division
//   by zero anywhere in the expression.
// Timing:
//   A digit or an ignored character is taken in the idle state. '+', '-' or '='
//   after a plain number, or one that closes a divide by zero, passes through the
//   number and term states. An operator that closes a multiply or divide also waits
//   in the wait state while the serial unit handles one operand bit per cycle. The
//   result of '=' is registered as the block leaves the term state, after the number
//   state and, when a product or quotient is pending, the wait state.
// Reset clears all expression state; the block then takes characters at once.
// While the receiver stalls a result, the block keeps taking characters and only
// holds on the next '=' until the waiting beat is taken. After '=' the block
// starts a fresh expression by itself.
module integer_expression_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic        div_zero
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NUM  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_TERM = 4'b1000
  } state_t;

  state_t                state;
  char_kind_t            kind;
  mulop_t                pending_mulop;
  logic                  pending_sign;
  logic                  error_seen;
  logic [DATA_WIDTH-1:0] running_sum;
  logic [DATA_WIDTH-1:0] term_value;
  logic [DATA_WIDTH-1:0] number_acc;

  logic                  in_beat;
  logic                  is_digit;
  logic [DATA_WIDTH-1:0] digit_val;
  logic [DATA_WIDTH-1:0] number_acc_next;
  logic [DATA_WIDTH-1:0] running_sum_next;
  logic                  out_free;
  logic                  emit;
  md_ctl_t               md_ctl;
  logic                  md_done;
  logic [DATA_WIDTH-1:0] md_result;

  // Handshake and character decode
  always_comb begin
    in_stall  = (state != ST_IDLE);
    in_beat   = in_valid && !in_stall;
    is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    digit_val = DATA_WIDTH'(char_code - CH_ZERO);
    // times ten as two shifts and an add
    number_acc_next = (number_acc << 3) + (number_acc << 1) + digit_val;
    running_sum_next = pending_sign ? (running_sum - term_value)
                                    : (running_sum + term_value);
    out_free = !out_valid || !out_stall;
    emit     = (state == ST_TERM) && (kind == K_EQ) && out_free;
  end

  // Start the serial unit when a pending product or quotient closes, unless it divides by zero
  always_comb begin
    md_ctl.start  = 1'b0;
    md_ctl.is_div = (pending_mulop == OP_DIV);
    if (state == ST_NUM) begin
      if (pending_mulop == OP_MUL) begin
        md_ctl.start = 1'b1;
      end else if (pending_mulop == OP_DIV && number_acc != '0) begin
        md_ctl.start = 1'b1;
      end
    end
  end

  iee_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctl    (md_ctl),
    .op_a   (term_value),
    .op_b   (number_acc),
    .done   (md_done),
    .result (md_result)
  );

  // Parser state machine and expression registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      kind          <= K_EQ;
      pending_mulop <= OP_NONE;
      pending_sign  <= 1'b0;
      error_seen    <= 1'b0;
      running_sum   <= '0;
      term_value    <= '0;
      number_acc    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // raise the output beat on '=', drop it once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (is_digit) begin
              number_acc <= number_acc_next;
            end else begin
              case (char_code)
                CH_MUL: begin kind <= K_MUL; state <= ST_NUM; end
                CH_DIV: begin kind <= K_DIV; state <= ST_NUM; end
                CH_ADD: begin kind <= K_ADD; state <= ST_NUM; end
                CH_SUB: begin kind <= K_SUB; state <= ST_NUM; end
                CH_EQ:  begin kind <= K_EQ;  state <= ST_NUM; end
                default: begin
                end
              endcase
            end
          end
        end
        ST_NUM: begin
          // close the number into the product term
          number_acc <= '0;
          case (pending_mulop)
            OP_MUL: begin
              state <= ST_WAIT;
            end
            OP_DIV: begin
              if (number_acc == '0) begin
                error_seen <= 1'b1;
                term_value <= '0;
                state      <= ST_TERM;
              end else begin
                state <= ST_WAIT;
              end
            end
            default: begin
              term_value <= number_acc;
              state      <= ST_TERM;
            end
          endcase
        end
        ST_WAIT: begin
          if (md_done) begin
            term_value <= md_result;
            state      <= ST_TERM;
          end
        end
        ST_TERM: begin
          case (kind)
            K_MUL: begin
              pending_mulop <= OP_MUL;
              state         <= ST_IDLE;
            end
            K_DIV: begin
              pending_mulop <= OP_DIV;
              state         <= ST_IDLE;
            end
            K_ADD, K_SUB: begin
              running_sum   <= running_sum_next;
              term_value    <= '0;
              pending_mulop <= OP_NONE;
              pending_sign  <= (kind == K_SUB);
              state         <= ST_IDLE;
            end
            K_EQ: begin
              // hold until the output register is free, then emit and restart
              if (out_free) begin
                value         <= error_seen ? 32'd0 : 32'($signed(running_sum_next));
                div_zero      <= error_seen;
                running_sum   <= '0;
                term_value    <= '0;
                number_acc    <= '0;
                pending_mulop <= OP_NONE;
                pending_sign  <= 1'b0;
                error_seen    <= 1'b0;
                state         <= ST_IDLE;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/iee_muldiv.sv -----
// Bit-serial multiply and restoring divide unit, one bit per cycle; no new request is taken until done.
// Depends on iee_pkg for the data width, counter width and request struct.
module iee_muldiv (
  input  logic                          clk,
  input  logic                          rst,
  input  iee_pkg::md_ctl_t              ctl,
  input  logic [iee_pkg::DATA_WIDTH-1:0] op_a,
  input  logic [iee_pkg::DATA_WIDTH-1:0] op_b,
  output logic                          done,
  output logic [iee_pkg::DATA_WIDTH-1:0] result
);
  import iee_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_FIX  = 3'b100
  } md_state_t;

  md_state_t             state;
  logic [CNT_W-1:0]      cnt;
  logic                  is_div;
  logic                  neg;
  logic [DATA_WIDTH-1:0] acc;    // product, or partial remainder
  logic [DATA_WIDTH-1:0] sh_a;   // multiplicand, or dividend shifting into quotient
  logic [DATA_WIDTH-1:0] sh_b;   // multiplier, or divisor

  logic [DATA_WIDTH:0]   rem_sh;
  logic                  ge;
  logic [DATA_WIDTH:0]   diff;

  // One restoring step: shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh = {acc, sh_a[DATA_WIDTH-1]};
    ge     = (rem_sh >= {1'b0, sh_b});
    diff   = rem_sh - {1'b0, sh_b};
  end

  // Sequence: load, iterate over every bit, then fix the quotient sign and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MD_IDLE: begin
          if (ctl.start) begin
            is_div <= ctl.is_div;
            acc    <= '0;
            cnt    <= CNT_W'(DATA_WIDTH - 1);
            if (ctl.is_div) begin
              sh_a <= magnitude(op_a);
              sh_b <= magnitude(op_b);
              neg  <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
            end else begin
              sh_a <= op_a;
              sh_b <= op_b;
              neg  <= 1'b0;
            end
            state <= MD_RUN;
          end
        end
        MD_RUN: begin
          if (is_div) begin
            acc  <= ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            sh_a <= {sh_a[DATA_WIDTH-2:0], ge};
          end else begin
            if (sh_b[0]) begin
              acc <= acc + sh_a;
            end
            sh_a <= sh_a << 1;
            sh_b <= sh_b >> 1;
          end
          if (cnt == '0) begin
            state <= MD_FIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        MD_FIX: begin
          if (is_div) begin
            result <= neg ? (~sh_a + 1'b1) : sh_a;
          end else begin
            result <= acc;
          end
          done  <= 1'b1;
          state <= MD_IDLE;
        end
        default: begin
          state <= MD_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/integer_expression_evaluator_checker.sv -----
`timescale 1ns / 100ps
// Checker for the integer expression evaluator: watches both channels and predicts each result.
// Depends on iee_pkg; instantiated by integer_expression_evaluator_tb beside the block.
module integer_expression_evaluator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] value,
  input  logic        div_zero,
  output int          mismatch_count,
  output int          awaited_count,
  output int          result_count,
  output int          div_zero_count
);
  import iee_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        div_zero;
  } eval_result_t;

  // Predicted expression state
  logic [DATA_WIDTH-1:0] sum_acc;
  logic [DATA_WIDTH-1:0] term_acc;
  logic [DATA_WIDTH-1:0] num_acc;
  mulop_t                pend_op;
  logic                  minus;
  logic                  div_fault;

  eval_result_t awaited_results[$];

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    result_count   = 0;
    div_zero_count = 0;
  end

  // Quotient truncated toward zero, wrapping like the hardware does
  function automatic logic [DATA_WIDTH-1:0] signed_quotient(input logic [DATA_WIDTH-1:0] a,
                                                            input logic [DATA_WIDTH-1:0] b);
    logic [DATA_WIDTH-1:0] ua;
    logic [DATA_WIDTH-1:0] ub;
    logic [DATA_WIDTH-1:0] q;
    ua = a[DATA_WIDTH-1] ? -a : a;
    ub = b[DATA_WIDTH-1] ? -b : b;
    q  = ua / ub;
    return (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -q : q;
  endfunction

  task automatic clear_expression();
    sum_acc   = '0;
    term_acc  = '0;
    num_acc   = '0;
    pend_op   = OP_NONE;
    minus     = 1'b0;
    div_fault = 1'b0;
  endtask

  // Apply the number just read to the product term
  task automatic fold_number();
    case (pend_op)
      OP_MUL: term_acc = term_acc * num_acc;
      OP_DIV: begin
        if (num_acc == '0) begin
          div_fault = 1'b1;
          term_acc  = '0;
        end else begin
          term_acc = signed_quotient(term_acc, num_acc);
        end
      end
      default: term_acc = num_acc;
    endcase
    num_acc = '0;
  endtask

  // Add or subtract the finished term
  task automatic fold_term();
    sum_acc  = minus ? sum_acc - term_acc : sum_acc + term_acc;
    term_acc = '0;
    pend_op  = OP_NONE;
  endtask

  task automatic eval_char(input logic [7:0] c);
    eval_result_t             r;
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]       wide;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      num_acc = num_acc * RADIX + (c - CH_ZERO);
    end else begin
      case (c)
        CH_MUL, CH_DIV: begin
          fold_number();
          pend_op = (c == CH_MUL) ? OP_MUL : OP_DIV;
        end
        CH_ADD, CH_SUB: begin
          fold_number();
          fold_term();
          minus = (c == CH_SUB);
        end
        CH_EQ: begin
          fold_number();
          fold_term();
          s = sum_acc;
          wide = s;
          r.value    = div_fault ? 32'd0 : wide[31:0];
          r.div_zero = div_fault;
          awaited_results.push_back(r);
          clear_expression();
        end
        default: ;
      endcase
    end
  endtask

  // Check output beats first, then fold in the accepted character
  always @(posedge clk) begin
    eval_result_t r;
    if (rst) begin
      clear_expression();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with no expression pending: value %0d div_zero %0b",
                     $time, $signed(value), div_zero);
        end else begin
          r = awaited_results.pop_front();
          result_count++;
          if (r.div_zero) div_zero_count++;
          if (value !== r.value || div_zero !== r.div_zero) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result mismatch: value exp %0d got %0d, div_zero exp %0b got %0b",
                       $time, $signed(r.value), $signed(value), r.div_zero, div_zero);
          end
        end
      end
      if (in_valid && !in_stall) eval_char(char_code);
    end
    awaited_count = awaited_results.size();
  end

endmodule

// ----- verif/integer_expression_evaluator_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the integer expression evaluator: clock, reset, character stimulus, verdict.
// Depends on iee_pkg, the block and integer_expression_evaluator_checker.
module integer_expression_evaluator_tb;
  import iee_pkg::*;

  localparam int CHAR_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = DATA_WIDTH + 8;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  char_code = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] value;
  logic        div_zero;

  int mismatch_total;
  int awaited_total;
  int results_checked;
  int div_zero_results;

  int         sent_chars = 0;
  int         expr_total = 0;
  bit         in_calm    = 1'b0;
  bit         out_calm   = 1'b0;
  int         out_hold   = 0;
  logic [7:0] line_q[$];

  integer_expression_evaluator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .div_zero  (div_zero)
  );

  integer_expression_evaluator_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .div_zero       (div_zero),
    .mismatch_count (mismatch_total),
    .awaited_count  (awaited_total),
    .result_count   (results_checked),
    .div_zero_count (div_zero_results)
  );

  always #2 clk = ~clk;

  // Stall result beats for a random count per beat, with calm stretches
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 15) == 0) out_calm = ~out_calm;
      out_hold = out_calm ? 0 : $urandom_range(0, 8);
    end else if (out_valid && out_hold > 0) begin
      out_hold = out_hold - 1;
    end
    out_stall <= (out_hold > 0);
  end

  // Drive one character beat after a random gap and hold it until taken
  task automatic send_beat(input logic [7:0] c);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_ADD || c == CH_SUB ||
        c == CH_MUL || c == CH_DIV || c == CH_EQ)
      sent_chars++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_line();
    while (line_q.size() > 0) send_beat(line_q.pop_front());
    expr_total++;
  endtask

  // Append an operand: mostly short numbers, some missing, some that wrap
  task automatic push_operand();
    int cls;
    int len;
    cls = $urandom_range(0, 15);
    len = 0;
    if (cls == 0) len = 0;
    else if (cls <= 5) len = 1;
    else if (cls <= 10) len = $urandom_range(2, 3);
    else if (cls <= 12) len = $urandom_range(4, 6);
    else if (cls == 13) len = $urandom_range(9, 12);
    else begin
      case ($urandom_range(0, 2))
        0: push_text("2147483648");
        1: push_text("4294967295");
        default: push_text("2147483647");
      endcase
    end
    for (int i = 0; i < len; i++) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) line_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Build one random expression, ending in '='
  task automatic build_expression();
    string pool;
    int    n_terms;
    pool = "0123456789+-*/= ";
    if ($urandom_range(0, 7) == 0) begin
      // broken sequence: stray operators, digits and spaces
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 5) == 0) line_q.push_back(8'($urandom_range(0, 255)));
        else line_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      end
    end else begin
      n_terms = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) line_q.push_back(CH_SUB);
      for (int t = 0; t < n_terms; t++) begin
        push_operand();
        maybe_noise();
        if (t < n_terms - 1) begin
          case ($urandom_range(0, 3))
            0: line_q.push_back(CH_ADD);
            1: line_q.push_back(CH_SUB);
            2: line_q.push_back(CH_MUL);
            default: line_q.push_back(CH_DIV);
          endcase
          maybe_noise();
        end
      end
    end
    line_q.push_back(CH_EQ);
  endtask

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still awaited", CYCLE_LIMIT, awaited_total);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty expression, leading minus, ignored codes with a zero
    // divisor, and a product that wraps followed by a truncating divide
    push_text("=");
    send_line();
    push_text("-5=");
    send_line();
    line_q.push_back(8'h00);
    push_text("8*");
    line_q.push_back(8'hFF);
    push_text("6/0=");
    send_line();
    push_text("65536*65536-7/2=");
    send_line();

    // Random expressions with calm stretches on the input side
    while (sent_chars < CHAR_TARGET) begin
      if ($urandom_range(0, 7) == 0) in_calm = ~in_calm;
      build_expression();
      send_line();
    end
    in_valid <= 1'b0;

    // Drain results, then let the block settle
    @(posedge clk);
    while (awaited_total != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d expressions with %0d operator and digit characters, idling on both sides.",
             expr_total, sent_chars);
    $display("Checked %0d results, %0d of them with a division by zero.",
             results_checked, div_zero_results);
    if (mismatch_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- integer_expression_evaluator.f -----
src/iee_pkg.sv
src/iee_muldiv.sv
src/integer_expression_evaluator.sv
verif/integer_expression_evaluator_checker.sv
verif/integer_expression_evaluator_tb.sv
